// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define PLAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// File: hdl/plau_pkg.sv
// Package for the periodic lattice address unit: widths, codes and item types.
// No dependencies.
package plau_pkg;

	localparam int MAX_DIMS_DEF    = 4;
	localparam int EXTENT_BITS_DEF = 8;

	localparam int NUM_DIMS   = 4;
	localparam int IDX_W      = 32;
	localparam int CRD_W      = 8;
	localparam int EXT_W      = 9;
	localparam int DIMS_W     = 3;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 9;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_PARTS  = IDX_W / DIV_STEPS;

	typedef enum logic [CMD_W-1:0] {
		CMD_SPLIT    = 2'd0,
		CMD_COMBINE  = 2'd1,
		CMD_RELATIVE = 2'd2,
		CMD_MIRROR   = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT3 = 3'd4;

	// effective lattice shape; unused dimensions carry extent 1
	typedef struct packed {
		logic [NUM_DIMS-1:0][EXT_W-1:0] ext;
		logic [NUM_DIMS-1:0]            used;
	} cfg_t;

	typedef struct packed {
		cmd_t                           cmd;
		logic [IDX_W-1:0]               idx;
		logic [CRD_W-1:0]               rem;
		logic [NUM_DIMS-1:0][CRD_W-1:0] a;
		logic [NUM_DIMS-1:0][CRD_W-1:0] b;
		logic [NUM_DIMS-1:0][CRD_W-1:0] c;
		logic                           err;
		logic [IDX_W-1:0]               acc;
	} item_t;

endpackage

// File: hdl/plau_entry.sv
// Entry stage: registers an item, checks coordinates and forms wrapped differences.
// Depends on plau_pkg.
module plau_entry (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  plau_pkg::item_t in_item,
	input  plau_pkg::cfg_t  cfg,
	output logic            out_vld,
	output plau_pkg::item_t out_item
);

	plau_pkg::item_t nxt;
	logic            vld_s1;
	plau_pkg::item_t item_s1;

	always_comb begin
		logic [plau_pkg::EXT_W-1:0] a9;
		logic [plau_pkg::EXT_W-1:0] b9;
		logic [plau_pkg::EXT_W-1:0] diff;
		nxt = in_item;
		nxt.rem = '0;
		nxt.acc = '0;
		nxt.err = 1'b0;
		nxt.c = '0;
		for (int i = 0; i < plau_pkg::NUM_DIMS; i++) begin
			a9 = {1'b0, in_item.a[i]};
			b9 = {1'b0, in_item.b[i]};
			diff = (b9 >= a9) ? (b9 - a9) : (b9 + cfg.ext[i] - a9);
			if (cfg.used[i]) begin
				if (in_item.cmd == plau_pkg::CMD_COMBINE) begin
					if (a9 >= cfg.ext[i])
						nxt.err = 1'b1;
					nxt.c[i] = in_item.a[i];
				end else if (in_item.cmd == plau_pkg::CMD_RELATIVE) begin
					if (a9 >= cfg.ext[i] || b9 >= cfg.ext[i])
						nxt.err = 1'b1;
					nxt.c[i] = diff[plau_pkg::CRD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			item_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

// File: hdl/plau_div_stage.sv
// Divider stage: eight restoring steps of index / extent for one dimension.
// Depends on plau_pkg.
module plau_div_stage #(
	parameter int DIM  = 0,
	parameter int PART = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  plau_pkg::item_t in_item,
	input  plau_pkg::cfg_t  cfg,
	output logic            out_vld,
	output plau_pkg::item_t out_item
);

	localparam bit LAST = (PART == plau_pkg::DIV_PARTS - 1);

	plau_pkg::item_t nxt;
	logic            vld_s1;
	plau_pkg::item_t item_s1;

	always_comb begin
		logic [plau_pkg::EXT_W-1:0] r9;
		logic                       ge;
		nxt = in_item;
		for (int s = 0; s < plau_pkg::DIV_STEPS; s++) begin
			r9 = {nxt.rem, nxt.idx[plau_pkg::IDX_W-1]};
			ge = (r9 >= cfg.ext[DIM]);
			nxt.idx = {nxt.idx[plau_pkg::IDX_W-2:0], ge};
			nxt.rem = ge ? plau_pkg::CRD_W'(r9 - cfg.ext[DIM]) : r9[plau_pkg::CRD_W-1:0];
		end
		if (LAST) begin
			if (in_item.cmd == plau_pkg::CMD_SPLIT || in_item.cmd == plau_pkg::CMD_MIRROR)
				nxt.c[DIM] = nxt.rem;
			nxt.rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			item_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

// File: hdl/plau_horner_stage.sv
// Horner stage: acc = c[DIM] + extent[DIM] * acc, one multiply per stage.
// Depends on plau_pkg.
module plau_horner_stage #(
	parameter int DIM = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  plau_pkg::item_t in_item,
	input  plau_pkg::cfg_t  cfg,
	output logic            out_vld,
	output plau_pkg::item_t out_item
);

	plau_pkg::item_t nxt;
	logic            vld_s1;
	plau_pkg::item_t item_s1;
	logic [plau_pkg::IDX_W+plau_pkg::EXT_W-1:0] prod;

	always_comb begin
		prod = {{plau_pkg::IDX_W{1'b0}}, cfg.ext[DIM]} *
			{{plau_pkg::EXT_W{1'b0}}, in_item.acc};
		nxt = in_item;
		nxt.acc = prod[plau_pkg::IDX_W-1:0] + plau_pkg::IDX_W'(in_item.c[DIM]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			item_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

// File: hdl/periodic_lattice_address_unit.sv
// Periodic lattice address unit: pipelined mixed-radix index conversion.
// Pipeline depth: 5*MAX_DIMS+2 register stages (22 by default).
// Throughput: one item per cycle when not stalled; the 32-bit divide runs 8 quotient bits per
// stage per dimension. Stalls back-propagate per stage, so bubbles are squeezed out.
// Reset: asynchronous, clears valids; configuration returns to one dimension of extent 1.
// Depends on plau_pkg, plau_entry, plau_div_stage, plau_horner_stage.
module periodic_lattice_address_unit #(
	parameter int MAX_DIMS    = plau_pkg::MAX_DIMS_DEF,
	parameter int EXTENT_BITS = plau_pkg::EXTENT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [plau_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [plau_pkg::CFG_W-1:0]     wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [plau_pkg::CMD_W-1:0]     command,
	input  logic [plau_pkg::IDX_W-1:0]     site_index,
	input  logic [plau_pkg::CRD_W-1:0]     coord_a_0,
	input  logic [plau_pkg::CRD_W-1:0]     coord_a_1,
	input  logic [plau_pkg::CRD_W-1:0]     coord_a_2,
	input  logic [plau_pkg::CRD_W-1:0]     coord_a_3,
	input  logic [plau_pkg::CRD_W-1:0]     coord_b_0,
	input  logic [plau_pkg::CRD_W-1:0]     coord_b_1,
	input  logic [plau_pkg::CRD_W-1:0]     coord_b_2,
	input  logic [plau_pkg::CRD_W-1:0]     coord_b_3,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [plau_pkg::IDX_W-1:0]     result_index,
	output logic [plau_pkg::CRD_W-1:0]     out_coord_0,
	output logic [plau_pkg::CRD_W-1:0]     out_coord_1,
	output logic [plau_pkg::CRD_W-1:0]     out_coord_2,
	output logic [plau_pkg::CRD_W-1:0]     out_coord_3,
	output logic                           range_error
);

	localparam int NDIV   = MAX_DIMS * plau_pkg::DIV_PARTS;
	localparam int PREP   = NDIV + 1;
	localparam int NST    = PREP + MAX_DIMS + 1;
	localparam logic [plau_pkg::EXT_W-1:0]  EXT_CAP  = plau_pkg::EXT_W'(1 << EXTENT_BITS);
	localparam logic [plau_pkg::DIMS_W-1:0] DIMS_CAP = plau_pkg::DIMS_W'(MAX_DIMS);

	logic [plau_pkg::DIMS_W-1:0]                     dims_q;
	logic [plau_pkg::NUM_DIMS-1:0][plau_pkg::EXT_W-1:0] ext_q;
	logic [plau_pkg::DIMS_W-1:0]                     nd_eff;
	plau_pkg::cfg_t                                  cfg;

	plau_pkg::item_t in_item;
	plau_pkg::item_t stg_item [0:NST-1];
	logic [NST-1:0]  stg_vld;
	logic [NST:0]    en;

	plau_pkg::item_t prep_nxt;
	plau_pkg::item_t prep_item_s1;
	logic            prep_vld_s1;
	plau_pkg::item_t out_nxt;
	plau_pkg::item_t out_item_s1;
	logic            out_vld_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= plau_pkg::DIMS_W'(1);
			ext_q  <= {plau_pkg::NUM_DIMS{plau_pkg::EXT_W'(1)}};
		end else if (wr_en) begin
			case (wr_index)
				plau_pkg::REG_DIMS: dims_q   <= wr_data[plau_pkg::DIMS_W-1:0];
				plau_pkg::REG_EXT0: ext_q[0] <= wr_data;
				plau_pkg::REG_EXT1: ext_q[1] <= wr_data;
				plau_pkg::REG_EXT2: ext_q[2] <= wr_data;
				plau_pkg::REG_EXT3: ext_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (dims_q == '0)
			nd_eff = plau_pkg::DIMS_W'(1);
		else if (dims_q > DIMS_CAP)
			nd_eff = DIMS_CAP;
		else
			nd_eff = dims_q;
		for (int i = 0; i < plau_pkg::NUM_DIMS; i++) begin
			cfg.used[i] = (plau_pkg::DIMS_W'(i) < nd_eff);
			if (!cfg.used[i] || ext_q[i] == '0)
				cfg.ext[i] = plau_pkg::EXT_W'(1);
			else if (ext_q[i] > EXT_CAP)
				cfg.ext[i] = EXT_CAP;
			else
				cfg.ext[i] = ext_q[i];
		end
	end

	always_comb begin
		in_item      = '0;
		in_item.cmd  = plau_pkg::cmd_t'(command);
		in_item.idx  = site_index;
		in_item.a[0] = coord_a_0;
		in_item.a[1] = coord_a_1;
		in_item.a[2] = coord_a_2;
		in_item.a[3] = coord_a_3;
		in_item.b[0] = coord_b_0;
		in_item.b[1] = coord_b_1;
		in_item.b[2] = coord_b_2;
		in_item.b[3] = coord_b_3;
	end

	// stage k loads when empty or when the stage after it moves
	always_comb begin
		en[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--)
			en[k] = !stg_vld[k] || en[k+1];
	end
	assign in_stall = !en[0];

	plau_entry u_entry (
		.clk(clk), .arst_n(arst_n), .en(en[0]), .in_vld(in_valid), .in_item(in_item),
		.cfg(cfg), .out_vld(stg_vld[0]), .out_item(stg_item[0])
	);

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		plau_div_stage #(
			.DIM(k / plau_pkg::DIV_PARTS),
			.PART(k % plau_pkg::DIV_PARTS)
		) u_div (
			.clk(clk), .arst_n(arst_n), .en(en[k+1]), .in_vld(stg_vld[k]),
			.in_item(stg_item[k]), .cfg(cfg), .out_vld(stg_vld[k+1]),
			.out_item(stg_item[k+1])
		);
	end

	// index range check, mirroring, Horner seed
	always_comb begin
		prep_nxt = stg_item[NDIV];
		if (prep_nxt.cmd == plau_pkg::CMD_SPLIT || prep_nxt.cmd == plau_pkg::CMD_MIRROR)
			prep_nxt.err = (prep_nxt.idx != '0);
		if (prep_nxt.cmd == plau_pkg::CMD_MIRROR) begin
			for (int i = 0; i < plau_pkg::NUM_DIMS; i++) begin
				if (stg_item[NDIV].c[i] != '0)
					prep_nxt.c[i] = plau_pkg::CRD_W'(cfg.ext[i] - {1'b0, stg_item[NDIV].c[i]});
			end
		end
		prep_nxt.acc = plau_pkg::IDX_W'(prep_nxt.c[MAX_DIMS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s1 <= 1'b0;
		end else if (en[PREP]) begin
			prep_vld_s1 <= stg_vld[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en[PREP] && stg_vld[NDIV]) begin
			prep_item_s1 <= prep_nxt;
		end
	end

	assign stg_vld[PREP]  = prep_vld_s1;
	assign stg_item[PREP] = prep_item_s1;

	for (genvar h = 0; h < MAX_DIMS - 1; h++) begin : g_horner
		plau_horner_stage #(
			.DIM(MAX_DIMS - 2 - h)
		) u_horner (
			.clk(clk), .arst_n(arst_n), .en(en[PREP+1+h]), .in_vld(stg_vld[PREP+h]),
			.in_item(stg_item[PREP+h]), .cfg(cfg), .out_vld(stg_vld[PREP+1+h]),
			.out_item(stg_item[PREP+1+h])
		);
	end

	// output register: select fields by command, zero on error
	always_comb begin
		out_nxt = stg_item[NST-2];
		if (out_nxt.err || out_nxt.cmd == plau_pkg::CMD_SPLIT ||
			out_nxt.cmd == plau_pkg::CMD_RELATIVE)
			out_nxt.acc = '0;
		if (out_nxt.err || out_nxt.cmd == plau_pkg::CMD_COMBINE ||
			out_nxt.cmd == plau_pkg::CMD_MIRROR)
			out_nxt.c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
		end else if (en[NST-1]) begin
			out_vld_s1 <= stg_vld[NST-2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1] && stg_vld[NST-2]) begin
			out_item_s1 <= out_nxt;
		end
	end

	assign stg_vld[NST-1]  = out_vld_s1;
	assign stg_item[NST-1] = out_item_s1;

	assign out_valid    = out_vld_s1;
	assign result_index = out_item_s1.acc;
	assign out_coord_0  = out_item_s1.c[0];
	assign out_coord_1  = out_item_s1.c[1];
	assign out_coord_2  = out_item_s1.c[2];
	assign out_coord_3  = out_item_s1.c[3];
	assign range_error  = out_item_s1.err;

endmodule

// File: hdl/plau_checker.sv
// Port-level checker for the periodic lattice address unit, with its bind.
// Depends on assert_macros.svh and plau_pkg.
`include "assert_macros.svh"

module plau_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [plau_pkg::IDX_W-1:0] result_index,
	input logic [plau_pkg::CRD_W-1:0] out_coord_0,
	input logic [plau_pkg::CRD_W-1:0] out_coord_1,
	input logic [plau_pkg::CRD_W-1:0] out_coord_2,
	input logic [plau_pkg::CRD_W-1:0] out_coord_3,
	input logic                       range_error
);

	`PLAU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`PLAU_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(result_index) && $stable(range_error))
	`PLAU_ASSERT_SAME(a_err_zero, clk, arst_n, out_valid && range_error, result_index == '0 && out_coord_0 == '0 && out_coord_1 == '0 && out_coord_2 == '0 && out_coord_3 == '0)
	`PLAU_ASSERT_SAME(a_index_xor_coord, clk, arst_n, out_valid && result_index != '0, out_coord_0 == '0 && out_coord_1 == '0 && out_coord_2 == '0 && out_coord_3 == '0)
	`PLAU_ASSERT_SAME(a_drain_ready, clk, arst_n, !out_stall, !in_stall)

endmodule

bind periodic_lattice_address_unit plau_checker u_plau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.result_index(result_index),
	.out_coord_0(out_coord_0),
	.out_coord_1(out_coord_1),
	.out_coord_2(out_coord_2),
	.out_coord_3(out_coord_3),
	.range_error(range_error)
);
